// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold in the same cycle as en
`define ASSERT_ALWAYS(name, en, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (en) |-> (cond)) \
		else $error("assertion failed");

// cond must hold in the cycle after en
`define ASSERT_NEXT(name, en, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (en) |=> (cond)) \
		else $error("assertion failed");

`endif

// ----- rtl/ddodo_pkg.sv -----
// ----------------------------------------------------------------------------
// ddodo_pkg
// Shared constants, angle table and control types for the odometry block.
// ----------------------------------------------------------------------------
package ddodo_pkg;

	localparam int ZW = 34;         // CORDIC angle width, Q4.30
	localparam int XW = 32;         // CORDIC vector width, Q2.30
	localparam int IW = 5;          // angle table index width
	localparam int TABLE_LEN = 24;

	localparam logic signed [ZW-1:0] PI_WORK      = ZW'(64'sd3373259426);
	localparam logic signed [ZW-1:0] HALF_PI_WORK = ZW'(64'sd1686629713);
	localparam logic signed [XW-1:0] CORDIC_GAIN  = XW'(64'sd652032874);

	typedef struct packed {
		logic start;
	} cordic_ctl_t;

	typedef struct packed {
		logic busy;
	} cordic_sts_t;

	function automatic logic signed [ZW-1:0] atan_work(input logic [IW-1:0] idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			5'd0:  v = ZW'(64'sd843314857);
			5'd1:  v = ZW'(64'sd497837829);
			5'd2:  v = ZW'(64'sd263043837);
			5'd3:  v = ZW'(64'sd133525159);
			5'd4:  v = ZW'(64'sd67021687);
			5'd5:  v = ZW'(64'sd33543516);
			5'd6:  v = ZW'(64'sd16775851);
			5'd7:  v = ZW'(64'sd8388437);
			5'd8:  v = ZW'(64'sd4194283);
			5'd9:  v = ZW'(64'sd2097149);
			5'd10: v = ZW'(64'sd1048576);
			5'd11: v = ZW'(64'sd524288);
			5'd12: v = ZW'(64'sd262144);
			5'd13: v = ZW'(64'sd131072);
			5'd14: v = ZW'(64'sd65536);
			5'd15: v = ZW'(64'sd32768);
			5'd16: v = ZW'(64'sd16384);
			5'd17: v = ZW'(64'sd8192);
			5'd18: v = ZW'(64'sd4096);
			5'd19: v = ZW'(64'sd2048);
			5'd20: v = ZW'(64'sd1024);
			5'd21: v = ZW'(64'sd512);
			5'd22: v = ZW'(64'sd256);
			5'd23: v = ZW'(64'sd128);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/ddodo_cordic.sv -----
// ----------------------------------------------------------------------------
// ddodo_cordic
// Iterative rotation-mode CORDIC: cosine and sine of a heading, one
// micro-rotation per cycle on a single shift-add unit.
// ----------------------------------------------------------------------------
module ddodo_cordic #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ddodo_pkg::cordic_ctl_t               ctl,
	input  logic signed [FRAC_BITS+3:0]          angle,
	output ddodo_pkg::cordic_sts_t               sts,
	output logic signed [ddodo_pkg::XW-1:0]      cos_val,
	output logic signed [ddodo_pkg::XW-1:0]      sin_val
);

	localparam int STEPS = (CORDIC_STEPS > ddodo_pkg::TABLE_LEN) ?
		ddodo_pkg::TABLE_LEN : CORDIC_STEPS;
	localparam int CW = $clog2(STEPS);
	localparam int SH = 30 - FRAC_BITS;
	localparam int ZW = ddodo_pkg::ZW;
	localparam int XW = ddodo_pkg::XW;

	logic                 busy_q;
	logic [CW-1:0]        cnt_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic                 neg_q;

	logic signed [ZW-1:0] z_ext, z_init;
	logic                 neg_init;
	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] atan_v;

	assign z_ext = ZW'(angle) <<< SH;

	// fold into the right half-plane, negate the vector at the end
	always_comb begin
		priority if (z_ext > ddodo_pkg::HALF_PI_WORK) begin
			z_init   = z_ext - ddodo_pkg::PI_WORK;
			neg_init = 1'b1;
		end else if (z_ext < -ddodo_pkg::HALF_PI_WORK) begin
			z_init   = z_ext + ddodo_pkg::PI_WORK;
			neg_init = 1'b1;
		end else begin
			z_init   = z_ext;
			neg_init = 1'b0;
		end
	end

	assign xs     = x_q >>> cnt_q;
	assign ys     = y_q >>> cnt_q;
	assign atan_v = ddodo_pkg::atan_work(ddodo_pkg::IW'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= ddodo_pkg::CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= z_init;
			neg_q <= neg_init;
		end else if (busy_q) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end
		end
	end

	assign sts.busy = busy_q;
	assign cos_val  = neg_q ? -x_q : x_q;
	assign sin_val  = neg_q ? -y_q : y_q;

endmodule

// ----- rtl/differential_drive_odometry_top.sv -----
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Dead-reckoning pose from cumulative left/right wheel distances.
// ----------------------------------------------------------------------------
// Input stream s_*: one odometry tick per request; s_tdata carries the two
// cumulative wheel distances, s_tuser the clear flag. Output stream m_*: one
// pose per tick (x, y, heading). cfg_*: writes the reciprocal wheel base at
// any time the block is idle; cfg_ready is always high.
// Each tick goes through a small sequencer around one shared 33x33
// multiplier: heading change, reciprocal estimate of the 2*pi quotient,
// quotient times 2*pi, then dx and dy. At most two compare-and-subtract
// steps finish the heading remainder while an iterative CORDIC, one
// micro-rotation per cycle, runs alongside; the sequencer waits in S_WAIT_C
// until the CORDIC is no longer busy, then forms dx and dy. The next tick
// is accepted only once the pose has left S_DONE for the output register.
// A clear request zeroes the pose and goes straight to S_DONE.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register, so the next tick is accepted while a pose still waits;
// if that pose is not taken, the following result waits in the sequencer.
// Reset zeroes the pose and the stored distances and loads a wheel-base
// reciprocal of 5.0 (0.2 m).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module differential_drive_odometry_top #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // left_distance, right_distance
	input  logic [0:0]  s_tuser,   // clear_pose
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // pos_x, pos_y, heading, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data   // inv_wheel_base
);

	localparam int HW        = FRAC_BITS + 4;
	localparam int SW        = 42;
	localparam int QS        = 9;
	localparam int XW        = ddodo_pkg::XW;

	localparam logic [63:0] PI_Q64 = (64'(ddodo_pkg::PI_WORK) +
		(64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
	localparam logic signed [HW-1:0] PI_Q   = PI_Q64[HW-1:0];
	localparam logic signed [HW-1:0] TWO_PI = HW'(2 * PI_Q64);

	// quotient estimate: (|sum| >> QS) * RECIP >> 32 lies at most 2 below
	localparam logic [63:0]        TP64    = 64'd2 * PI_Q64;
	localparam logic [63:0]        RECIP64 = (64'd1 << (QS + 32)) / TP64;
	localparam logic signed [32:0] RECIP_M = $signed(RECIP64[32:0]);
	localparam logic signed [32:0] TP_M    = $signed(TP64[32:0]);
	localparam logic [SW-1:0]      TP_W    = TP64[SW-1:0];
	localparam logic [SW-1:0]      REM_MAX = SW'(64'd3 * TP64);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_TH,
		S_SUM,
		S_MUL_Q,
		S_MUL_R,
		S_SUB,
		S_FIX,
		S_WAIT_C,
		S_MUL_X,
		S_MUL_Y,
		S_ACC_Y,
		S_DONE
	} state_t;

	state_t state_q;

	logic                 m_tvalid_q;
	logic [23:0]          inv_q;
	logic signed [31:0]   acc_x_q, acc_y_q;
	logic signed [HW-1:0] acc_heading_q;
	logic signed [31:0]   last_left_q, last_right_q;

	logic signed [32:0]   diff_q;
	logic signed [31:0]   dc_q;
	logic signed [65:0]   prod_q;
	logic [SW-1:0]        sabs_q, rem_q;
	logic                 rneg_q;
	logic [31:0]          out_x_q, out_y_q;
	logic [18:0]          out_h_q;

	logic                 accept, clear, load_out;
	logic signed [31:0]   left, right, dl, dr, dc_n;
	logic signed [32:0]   diff_n, dsum;
	logic signed [32:0]   mul_a, mul_b;
	logic signed [SW-1:0] dth, sum_n, sum_abs;
	logic signed [35:0]   nx, ny;
	logic signed [HW-1:0] hv, hn, head_w;
	logic signed [HW+18:0] head_ext;

	ddodo_pkg::cordic_ctl_t    cordic_ctl;
	ddodo_pkg::cordic_sts_t    cordic_sts;
	logic signed [XW-1:0]      cos_val, sin_val;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		priority if (v > 36'sh07FFFFFFF) r = 32'sh7FFFFFFF;
		else if (v < 36'shF80000000) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign clear     = s_tuser[0];
	assign cfg_ready = 1'b1;

	// wheel deltas wrap modulo 2^32
	assign left   = s_tdata[31:0];
	assign right  = s_tdata[63:32];
	assign dl     = left - last_left_q;
	assign dr     = right - last_right_q;
	assign diff_n = 33'(dr) - 33'(dl);
	assign dsum   = 33'(dl) + 33'(dr);
	assign dc_n   = dsum[32:1];

	assign cordic_ctl.start = accept && !clear;

	ddodo_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.FRAC_BITS   (FRAC_BITS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cordic_ctl),
		.angle  (acc_heading_q),
		.sts    (cordic_sts),
		.cos_val(cos_val),
		.sin_val(sin_val)
	);

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_MUL_TH: begin
				mul_a = diff_q;
				mul_b = $signed({9'b0, inv_q});
			end
			S_MUL_Q: begin
				mul_a = $signed({1'b0, sabs_q[QS+31:QS]});
				mul_b = RECIP_M;
			end
			S_MUL_R: begin
				mul_a = $signed({1'b0, prod_q[63:32]});
				mul_b = TP_M;
			end
			S_MUL_Y: begin
				mul_a = 33'(dc_q);
				mul_b = 33'(sin_val);
			end
			default: begin
				mul_a = 33'(dc_q);
				mul_b = 33'(cos_val);
			end
		endcase
	end

	assign dth     = prod_q[57:16];
	assign sum_n   = SW'(acc_heading_q) + dth;
	assign sum_abs = sum_n[SW-1] ? -sum_n : sum_n;

	assign nx = 36'(acc_x_q) + prod_q[65:30];
	assign ny = 36'(acc_y_q) + prod_q[65:30];

	// truncated remainder back to a signed heading, then into [-pi, pi]
	assign hv = {1'b0, rem_q[HW-2:0]};
	assign hn = rneg_q ? -hv : hv;
	always_comb begin
		priority if (hn > PI_Q) head_w = hn - TWO_PI;
		else if (hn < -PI_Q) head_w = hn + TWO_PI;
		else head_w = hn;
	end

	assign head_ext = (HW + 19)'(acc_heading_q);
	assign load_out = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			m_tvalid_q    <= 1'b0;
			inv_q         <= 24'd327680;
			acc_x_q       <= '0;
			acc_y_q       <= '0;
			acc_heading_q <= '0;
			last_left_q   <= '0;
			last_right_q  <= '0;
		end else begin
			if (cfg_valid) begin
				inv_q <= cfg_data;
			end

			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_left_q  <= left;
						last_right_q <= right;
						if (clear) begin
							acc_x_q       <= '0;
							acc_y_q       <= '0;
							acc_heading_q <= '0;
							state_q       <= S_DONE;
						end else begin
							state_q <= S_MUL_TH;
						end
					end
				end
				S_MUL_TH: state_q <= S_SUM;
				S_SUM:    state_q <= S_MUL_Q;
				S_MUL_Q:  state_q <= S_MUL_R;
				S_MUL_R:  state_q <= S_SUB;
				S_SUB:    state_q <= S_FIX;
				S_FIX: begin
					if (rem_q < TP_W) begin
						state_q <= S_WAIT_C;
					end
				end
				S_WAIT_C: begin
					if (!cordic_sts.busy) begin
						state_q <= S_MUL_X;
					end
				end
				S_MUL_X: state_q <= S_MUL_Y;
				S_MUL_Y: begin
					acc_x_q <= sat32(nx);
					state_q <= S_ACC_Y;
				end
				S_ACC_Y: begin
					acc_y_q       <= sat32(ny);
					acc_heading_q <= head_w;
					state_q       <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_q <= diff_n;
			dc_q   <= dc_n;
		end
		if (state_q == S_MUL_TH || state_q == S_MUL_Q || state_q == S_MUL_R ||
				state_q == S_MUL_X || state_q == S_MUL_Y) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == S_SUM) begin
			sabs_q <= $unsigned(sum_abs);
			rneg_q <= sum_n[SW-1];
		end
		if (state_q == S_SUB) begin
			rem_q <= sabs_q - prod_q[SW-1:0];
		end else if (state_q == S_FIX && rem_q >= TP_W) begin
			rem_q <= rem_q - TP_W;
		end
		if (load_out) begin
			out_x_q <= acc_x_q;
			out_y_q <= acc_y_q;
			out_h_q <= head_ext[18:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_h_q, out_y_q, out_x_q};

	`ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)
	`ASSERT_NEXT(a_clear_zero, accept && clear,
		acc_x_q == '0 && acc_y_q == '0 && acc_heading_q == '0)
	`ASSERT_ALWAYS(a_heading_range, 1'b1, acc_heading_q <= PI_Q && acc_heading_q >= -PI_Q)
	`ASSERT_ALWAYS(a_rem_bound, state_q == S_FIX, rem_q < REM_MAX)
	`ASSERT_ALWAYS(a_cordic_done, state_q == S_MUL_X, !cordic_sts.busy)

endmodule

// ----- sim/differential_drive_odometry_checker.sv -----
// ----------------------------------------------------------------------------
// differential_drive_odometry_checker
// Watches the tick, pose and wheel-base channels. It keeps its own
// dead-reckoning pose (wheel deltas, CORDIC rotation, 2*pi heading wrap,
// saturating position) and compares every pose request field by field with
// the oldest predicted pose.
// ----------------------------------------------------------------------------
module differential_drive_odometry_checker #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // left_distance, right_distance
	input  logic [0:0]  s_tuser,   // clear_pose
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,   // pos_x, pos_y, heading, zero pad
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [23:0] cfg_data,  // inv_wheel_base
	output int          fail_count,
	output int          pending,
	output int          pose_count
);

	localparam int     WORK_BITS   = 30;
	localparam int     ANGLE_SHIFT = WORK_BITS - FRAC_BITS;
	localparam int     ROT_STEPS   = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam longint PI_W        = longint'(ddodo_pkg::PI_WORK);
	localparam longint HALF_PI_W   = longint'(ddodo_pkg::HALF_PI_WORK);
	localparam longint GAIN_W      = longint'(ddodo_pkg::CORDIC_GAIN);
	localparam longint PI_Q        = (PI_W + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
	localparam longint TWO_PI_Q    = 2 * PI_Q;
	localparam longint POS_MAX     = 64'sd2147483647;
	localparam longint POS_MIN     = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [18:0] hdg;
	} pose_t;

	longint atan_tbl [0:23] = '{
		843314857, 497837829, 263043837, 133525159,
		67021687, 33543516, 16775851, 8388437,
		4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048,
		1024, 512, 256, 128
	};

	logic [23:0] wheel_inv  = 24'd327680;
	longint      x_acc      = 0;
	longint      y_acc      = 0;
	longint      head_acc   = 0;
	logic [31:0] last_left  = '0;
	logic [31:0] last_right = '0;
	pose_t       pose_q [$];
	pose_t       want;
	int          errs       = 0;
	int          waiting    = 0;
	int          checked    = 0;

	assign fail_count = errs;
	assign pending    = waiting;
	assign pose_count = checked;

	task automatic report(input string what, input longint got, input longint exp_val);
		if (errs < 40)
			$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, exp_val);
		errs++;
	endtask

	function automatic longint clamp32(input longint v);
		if (v > POS_MAX)
			return POS_MAX;
		if (v < POS_MIN)
			return POS_MIN;
		return v;
	endfunction

	// cos/sin of a heading in Q2.30, folded by pi beyond +-pi/2
	function automatic void rotate(input longint ang, output longint c, output longint s);
		longint z, x, y, nx, ny;
		bit     flip;
		int     i;
		z = ang * (64'sd1 <<< ANGLE_SHIFT);
		x = GAIN_W;
		y = 0;
		flip = 1'b0;
		if (z > HALF_PI_W) begin
			z -= PI_W;
			flip = 1'b1;
		end else if (z < -HALF_PI_W) begin
			z += PI_W;
			flip = 1'b1;
		end
		for (i = 0; i < ROT_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= atan_tbl[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += atan_tbl[i];
			end
			x = nx;
			y = ny;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic pose_t advance_pose(input logic [31:0] left, input logic [31:0] right,
			input logic clr);
		logic [31:0] du;
		longint      dl, dr, dc, dth, c, s, h;
		pose_t       p;
		if (clr) begin
			x_acc = 0;
			y_acc = 0;
			head_acc = 0;
		end else begin
			du = left - last_left;
			dl = longint'($signed(du));
			du = right - last_right;
			dr = longint'($signed(du));
			dc = (dl + dr) >>> 1;
			dth = ((dr - dl) * longint'(wheel_inv)) >>> 16;
			rotate(head_acc, c, s);
			x_acc = clamp32(x_acc + ((dc * c) >>> WORK_BITS));
			y_acc = clamp32(y_acc + ((dc * s) >>> WORK_BITS));
			h = (head_acc + dth) % TWO_PI_Q;
			if (h > PI_Q)
				h -= TWO_PI_Q;
			else if (h < -PI_Q)
				h += TWO_PI_Q;
			head_acc = h;
		end
		last_left = left;
		last_right = right;
		p.x = x_acc[31:0];
		p.y = y_acc[31:0];
		p.hdg = head_acc[18:0];
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_q.delete();
			wheel_inv = 24'd327680;
			x_acc = 0;
			y_acc = 0;
			head_acc = 0;
			last_left = '0;
			last_right = '0;
			waiting = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				wheel_inv = cfg_data;
			if (m_tvalid && m_tready) begin
				if (pose_q.size() == 0) begin
					report("unrequested pose, pos_x", $signed(m_tdata[31:0]), 0);
				end else begin
					want = pose_q.pop_front();
					if (m_tdata[31:0] !== want.x)
						report("pos_x", $signed(m_tdata[31:0]), want.x);
					if (m_tdata[63:32] !== want.y)
						report("pos_y", $signed(m_tdata[63:32]), want.y);
					if (m_tdata[82:64] !== want.hdg)
						report("heading", $signed(m_tdata[82:64]), want.hdg);
					checked++;
				end
			end
			if (s_tvalid && s_tready)
				pose_q.push_back(advance_pose(s_tdata[31:0], s_tdata[63:32], s_tuser[0]));
			waiting = pose_q.size();
		end
	end

endmodule

// ----- sim/differential_drive_odometry_top_test.sv -----
// ----------------------------------------------------------------------------
// differential_drive_odometry_top_test
// Drives odometry ticks into the block: a directed run through straight moves,
// turns in every quadrant, heading wrap both ways, counter roll-over, position
// saturation and clears, then random ticks under several wheel-base settings
// with random gaps and output stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top_test;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;   // left_distance, right_distance
	logic [0:0]  s_tuser   = '0;   // clear_pose
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [87:0] m_tdata;          // pos_x, pos_y, heading, zero pad
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [23:0] cfg_data  = '0;   // inv_wheel_base

	int          fail_count;
	int          pending;
	int          pose_count;
	bit          calm          = 1'b0;
	logic [31:0] cur_left      = '0;
	logic [31:0] cur_right     = '0;
	int          tick_count    = 0;
	int          clear_count   = 0;
	int          setting_count = 0;

	always #5 clk = ~clk;

	differential_drive_odometry_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	differential_drive_odometry_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.pose_count (pose_count)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(30, 120);
	endfunction

	task automatic send_tick(input logic [31:0] left, input logic [31:0] right,
			input logic clr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {right, left};
		s_tuser <= clr;
		do @(posedge clk); while (!s_tready);
		cur_left = left;
		cur_right = right;
		tick_count++;
		if (clr)
			clear_count++;
	endtask

	task automatic move(input int dl, input int dr);
		send_tick(cur_left + dl, cur_right + dr, 1'b0);
	endtask

	// sender holds off until every pose is back and the block is free
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || !s_tready) @(posedge clk);
	endtask

	task automatic write_wheel_base(input logic [23:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		setting_count++;
	endtask

	task automatic random_tick();
		int pick, span, dl, dr;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			send_tick($urandom, $urandom, 1'b1);
		end else if (pick < 64) begin
			span = 1 << $urandom_range(4, 18);
			dl = int'($urandom_range(0, 2 * span)) - span;
			dr = dl + int'($urandom_range(0, span)) - span / 2;
			move(dl, dr);
		end else if (pick < 84) begin
			send_tick($urandom, $urandom, 1'b0);
		end else begin
			dl = int'($urandom);
			dr = $urandom_range(0, 1) ? dl : int'($urandom);
			move(dl, dr);
		end
	endtask

	// pose sink: mostly ready, short stalls, now and then a long one
	initial begin
		int r;
		int len;
		forever begin
			r = $urandom_range(0, 99);
			if (calm || r < 70) begin
				m_tready <= 1'b1;
				len = calm ? 1 : $urandom_range(1, 12);
			end else begin
				m_tready <= 1'b0;
				if (r < 92)
					len = $urandom_range(1, 4);
				else if (r < 98)
					len = $urandom_range(5, 30);
				else
					len = $urandom_range(40, 100);
			end
			repeat (len) @(posedge clk);
		end
	end

	initial begin
		int          phase;
		logic [23:0] wb;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default base 0.2 m
		send_tick(32'd0, 32'd0, 1'b1);
		move(65536, 65536);
		move(65536, 131072);                     // large turn, wraps below
		move(65536, 65536);
		move(0, 26214);
		move(0, 19661);                          // past +pi/2
		move(131072, 131072);
		move(39322, 0);
		move(26214, 0);                          // past -pi/2
		move(131072, 131072);
		move(13107, 0);                          // below -pi, wraps up
		move(65536, 65536);
		send_tick(32'h7FFF_FFF0, 32'h7FFF_FFF0, 1'b0);
		move(32, 32);                            // counters roll over
		send_tick(32'd0, 32'd0, 1'b1);
		repeat (3) move(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		repeat (3) move(int'(32'h8000_0000), int'(32'h8000_0000));
		move(0, 20588);                          // about +pi/2
		repeat (2) move(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_tick(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_tick(32'h1234_5678, 32'h89AB_CDEF, 1'b1);
		move(0, 0);

		// zero reciprocal: no turning
		wait_idle();
		write_wheel_base(24'd0);
		move(0, 65536);
		move(65536, 0);

		for (phase = 0; phase < 6; phase++) begin
			wait_idle();
			case (phase)
				0: wb = 24'd1;
				1: wb = 24'hFF_FFFF;
				2: wb = 24'($urandom_range(1, 24'hFF_FFFF));
				3: wb = 24'd327680;
				4: wb = 24'($urandom_range(65536, 1048576));
				default: wb = 24'($urandom);
			endcase
			write_wheel_base(wb);
			calm = (phase == 3);
			repeat (138) random_tick();
		end
		calm = 1'b0;
		wait_idle();
		repeat (40) @(posedge clk);

		$display("Covered %0d ticks (%0d clears) over %0d wheel-base writes; %0d poses checked.",
			tick_count, clear_count, setting_count, pose_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
